>>> rtl/hbmt_pkg.sv
// Shared types, constants and a function of the hierarchical type best-match table.
`timescale 1ns / 1ps
package hbmt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int HANDLE_BITS = 16;
	localparam int KEY_BITS = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] FUNC_SET_ACTOR = 3'd0;
	localparam logic [2:0] FUNC_SET_RESOURCE = 3'd1;
	localparam logic [2:0] FUNC_REMOVE_ACTOR = 3'd2;
	localparam logic [2:0] FUNC_REMOVE_RESOURCE = 3'd3;
	localparam logic [2:0] FUNC_LOOKUP = 3'd4;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic is_set;
		logic is_remove;
		logic is_lookup;
		logic sel_actor;
		logic [KEY_BITS-1:0] key;
		logic [HANDLE_BITS-1:0] actor;
		logic [HANDLE_BITS-1:0] resource;
	} item_t;

	// One stored table entry.
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [HANDLE_BITS-1:0] actor;
		logic [HANDLE_BITS-1:0] resource;
	} entry_t;

	// Number of leading key fields (8,8,16,8,8,8,8 bits) that agree.
	function automatic logic [2:0] prefix_rank(input logic [KEY_BITS-1:0] a,
		input logic [KEY_BITS-1:0] b);
		logic [6:0] eq;
		logic run;
		logic [2:0] r;
		eq[0] = (a[63:56] == b[63:56]);
		eq[1] = (a[55:48] == b[55:48]);
		eq[2] = (a[47:32] == b[47:32]);
		eq[3] = (a[31:24] == b[31:24]);
		eq[4] = (a[23:16] == b[23:16]);
		eq[5] = (a[15:8] == b[15:8]);
		eq[6] = (a[7:0] == b[7:0]);
		run = 1'b1;
		r = 3'd0;
		for (int i = 0; i < 7; i++) begin
			run = run & eq[i];
			if (run) begin
				r = r + 3'd1;
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/hbmt_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module hbmt_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] func,
	input  logic [7:0] kind,
	input  logic [7:0] domain,
	input  logic [15:0] country,
	input  logic [7:0] category,
	input  logic [7:0] subcategory,
	input  logic [7:0] specific,
	input  logic [7:0] extra,
	input  logic [15:0] actor_in,
	input  logic [15:0] resource_in,
	output logic q_valid,
	output hbmt_pkg::item_t q_item,
	input  logic q_pop
);

	hbmt_pkg::item_t fifo_q [2];
	hbmt_pkg::item_t cls;
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic push;

	// Decode the function code into operation flags.
	always_comb begin
		cls.is_set = (func == hbmt_pkg::FUNC_SET_ACTOR) ||
			(func == hbmt_pkg::FUNC_SET_RESOURCE);
		cls.is_remove = (func == hbmt_pkg::FUNC_REMOVE_ACTOR) ||
			(func == hbmt_pkg::FUNC_REMOVE_RESOURCE);
		cls.is_lookup = (func == hbmt_pkg::FUNC_LOOKUP);
		cls.sel_actor = (func == hbmt_pkg::FUNC_SET_ACTOR) ||
			(func == hbmt_pkg::FUNC_REMOVE_ACTOR);
		cls.key = {kind, domain, country, category, subcategory, specific, extra};
		cls.actor = actor_in[hbmt_pkg::HANDLE_BITS-1:0];
		cls.resource = resource_in[hbmt_pkg::HANDLE_BITS-1:0];
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (count_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

>>> rtl/hbmt_back.sv
// Back end: scans the entry memory for each request, updates it and registers the result.
`timescale 1ns / 1ps
module hbmt_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  hbmt_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output logic found,
	output logic [2:0] match_rank,
	output logic [15:0] actor_out,
	output logic [15:0] resource_out,
	output logic table_full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [hbmt_pkg::CNT_W-1:0] LAST_CNT =
		hbmt_pkg::CNT_W'(hbmt_pkg::TABLE_ENTRIES);
	localparam int HB = hbmt_pkg::HANDLE_BITS;
	localparam int IW = hbmt_pkg::IDX_W;

	hbmt_pkg::entry_t mem_q [hbmt_pkg::TABLE_ENTRIES];
	hbmt_pkg::entry_t rd_word_s1, wd;
	hbmt_pkg::item_t item_q;
	logic [hbmt_pkg::TABLE_ENTRIES-1:0] valid_q;
	logic [1:0] state_q;
	logic [hbmt_pkg::CNT_W-1:0] cnt_q;
	logic pend_s1;
	logic [IW-1:0] pidx_s1, wa;
	logic exact_hit_q, free_hit_q, best_hit_q;
	logic [IW-1:0] exact_idx_q, free_idx_q;
	logic [HB-1:0] exact_act_q, exact_res_q, best_act_q, best_res_q;
	logic [2:0] best_rank_q, rank;
	logic [hbmt_pkg::KEY_BITS-1:0] best_key_q;
	logic re, we, v_set, v_clr, finish, ent_v, full_n;
	logic [HB-1:0] other;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign re = (state_q == ST_SCAN) && (cnt_q != LAST_CNT);
	assign finish = (state_q == ST_DONE) && (!out_valid || out_ready);
	assign ent_v = valid_q[pidx_s1];
	assign rank = hbmt_pkg::prefix_rank(rd_word_s1.key, item_q.key);

	// Table update at the end of a request.
	always_comb begin
		we = 1'b0;
		v_set = 1'b0;
		v_clr = 1'b0;
		full_n = 1'b0;
		wa = exact_hit_q ? exact_idx_q : free_idx_q;
		other = item_q.sel_actor ? exact_res_q : exact_act_q;
		wd.key = item_q.key;
		wd.actor = exact_hit_q ? exact_act_q : '0;
		wd.resource = exact_hit_q ? exact_res_q : '0;
		if (item_q.is_set) begin
			if (item_q.sel_actor) begin
				wd.actor = item_q.actor;
			end else begin
				wd.resource = item_q.resource;
			end
			if (exact_hit_q || free_hit_q) begin
				we = finish;
				v_set = finish;
			end else begin
				full_n = 1'b1;
			end
		end else if (item_q.is_remove && exact_hit_q) begin
			if (item_q.sel_actor) begin
				wd.actor = '0;
			end else begin
				wd.resource = '0;
			end
			if (other == '0) begin
				v_clr = finish;
			end else begin
				we = finish;
			end
		end
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd_word_s1 <= mem_q[cnt_q[IW-1:0]];
		end
	end

	// Request register and scan accumulators.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			exact_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
			best_hit_q <= 1'b0;
			best_rank_q <= 3'd0;
		end else if (pend_s1) begin
			if (ent_v && !exact_hit_q && rd_word_s1.key == item_q.key) begin
				exact_hit_q <= 1'b1;
				exact_idx_q <= pidx_s1;
				exact_act_q <= rd_word_s1.actor;
				exact_res_q <= rd_word_s1.resource;
			end
			if (!ent_v && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= pidx_s1;
			end
			if (ent_v && rank != 3'd0 && (rank > best_rank_q ||
				(rank == best_rank_q && rd_word_s1.key < best_key_q))) begin
				best_hit_q <= 1'b1;
				best_rank_q <= rank;
				best_key_q <= rd_word_s1.key;
				best_act_q <= rd_word_s1.actor;
				best_res_q <= rd_word_s1.resource;
			end
		end
	end

	// Result fields held for the receiver.
	always_ff @(posedge clk) begin
		if (finish) begin
			found <= item_q.is_lookup && best_hit_q;
			match_rank <= (item_q.is_lookup && best_hit_q) ? best_rank_q : 3'd0;
			actor_out <= (item_q.is_lookup && best_hit_q) ? 16'(best_act_q) : 16'd0;
			resource_out <= (item_q.is_lookup && best_hit_q) ? 16'(best_res_q) : 16'd0;
			table_full <= full_n;
		end
	end

	// Sequencer, read pipeline, valid bits and output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			pidx_s1 <= '0;
			valid_q <= '0;
			out_valid <= 1'b0;
		end else begin
			pend_s1 <= re;
			if (re) begin
				pidx_s1 <= cnt_q[IW-1:0];
				cnt_q <= cnt_q + hbmt_pkg::CNT_W'(1);
			end
			if (v_set) begin
				valid_q[wa] <= 1'b1;
			end
			if (v_clr) begin
				valid_q[exact_idx_q] <= 1'b0;
			end
			if (finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						cnt_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!re && !pend_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/hierarchical_type_best_match_table_core.sv
// Top level of the hierarchical type best-match table.
`timescale 1ns / 1ps
// Usage:
// Request beats (func, seven key fields, actor_in, resource_in) enter on
// in_valid/in_ready; every request yields exactly one result beat (found,
// match_rank, actor_out, resource_out, table_full) on out_valid/out_ready.
// The front end queues up to two requests, so beats are taken while the
// back end is busy or a result waits.
// The back end walks the 64-entry memory one entry per cycle through its
// single registered read port, then applies any update through its write port.
// It handles one request at a time: the next is taken from the queue only
// after the result of the last has been loaded into the output register.
// Reset empties the table (all valid bits cleared) and the queue; no
// clearing pass is needed. When the receiver stalls, the result is held
// in the output register and the back end waits before its table update.
module hierarchical_type_best_match_table_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] func,
	input  logic [7:0] kind,
	input  logic [7:0] domain,
	input  logic [15:0] country,
	input  logic [7:0] category,
	input  logic [7:0] subcategory,
	input  logic [7:0] specific,
	input  logic [7:0] extra,
	input  logic [15:0] actor_in,
	input  logic [15:0] resource_in,
	output logic out_valid,
	input  logic out_ready,
	output logic found,
	output logic [2:0] match_rank,
	output logic [15:0] actor_out,
	output logic [15:0] resource_out,
	output logic table_full
);

	hbmt_pkg::item_t q_item;
	logic q_valid, q_pop;

	hbmt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .kind(kind), .domain(domain), .country(country),
		.category(category), .subcategory(subcategory), .specific(specific),
		.extra(extra), .actor_in(actor_in), .resource_in(resource_in),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	hbmt_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
		.found(found), .match_rank(match_rank), .actor_out(actor_out),
		.resource_out(resource_out), .table_full(table_full)
	);

	// A found result always carries a nonzero rank.
	a_found_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> match_rank != 3'd0)
		else $error("found result with zero rank");

	// A full table report never comes with a lookup hit.
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !found)
		else $error("table_full and found together");

	// A miss reports no handles and no rank.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> actor_out == 16'd0 && resource_out == 16'd0 &&
		match_rank == 3'd0)
		else $error("miss result carries data");

endmodule
